>>> design/free_list_allocator_defines.svh
// Assertion macros used by the allocator module.
`ifndef FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FREE_LIST_ALLOCATOR_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define FLA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define FLA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/fla_pkg.sv
package fla_pkg;

  localparam int unsigned TableDepth = 64;
  localparam logic [31:0] PageMaskLow  = 32'h0000_0fff;
  localparam logic [31:0] PageMaskHigh = 32'hffff_f000;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StNoFit = 2'd1;
  localparam logic [1:0] StLost = 2'd2;

  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;

  localparam logic CfgFitPolicy = 1'b0;
  localparam logic CfgPageRound = 1'b1;

  // Table write request handed from the sequencer to the table store.
  typedef struct packed {
    logic        wen;
    logic [31:0] waddr_val;
    logic [31:0] wsize_val;
  } fla_wr_t;

endpackage

>>> design/fla_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fla_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/free_list_allocator.sv
// Channel | Direction | Ports                  | Item
// in      | slave     | in_tvalid/tready/tdata | request
// out     | master     | out_tvalid/tready/tdata | result
// cfg     | write      | cfg_valid/ready/index/data | register write
//
// One request at a time through a sequencer around a single table RAM pair.
// Alloc: one read per entry to scan, then a shift pass over the later entries
// when the picked entry empties.
// Free: a scan for the insert point, then a merge or an insert; an insert shifts
// the later entries up, and a merge of both neighbours shifts them down.
// Reset clears counters, state and config bits, not the table; table entries are written before read.
// The result waits in an output register; a new request is taken after it.
`include "free_list_allocator_defines.svh"
module free_list_allocator #(
  parameter int unsigned TABLE_DEPTH = fla_pkg::TableDepth
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [0] req_type, [32:1] range_start, [64:33] range_size, [71:65] zero
  input  logic [71:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] alloc_start, [33:32] status, [65:34] free_total,
  // [72:66] entry_count, [79:73] peak_entries, [111:80] lost_count,
  // [143:112] lost_bytes
  output logic [143:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic         cfg_data
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_SHR   = 4'd5;
  localparam logic [3:0] S_SHW   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]    state_r;
  logic          fit_r, round_r;
  logic          type_r;
  logic [31:0]   addr_r, size_r;
  logic [CW-1:0] used_r, peak_r;
  logic [31:0]   lostc_r, lostb_r, sum_r;
  logic [CW-1:0] k_r;           // scan / shift index
  logic          rvalid_r;      // read data of index rk_r arrives this cycle
  logic [CW-1:0] rk_r;
  logic          found_r;
  logic [AW-1:0] pick_r;
  logic [31:0]   best_r;
  logic [CW-1:0] pos_r;         // insert point i
  logic [31:0]   pa_r, ps_r;    // entry at pick or i-1
  logic [31:0]   na_r, ns_r;    // entry at i
  logic [2:0]    op_r;          // shift kind
  logic [31:0]   ostart_r;
  logic [1:0]    ostat_r;
  logic          ovalid_r;

  localparam logic [2:0] OP_DEL = 3'd0;
  localparam logic [2:0] OP_INS = 3'd1;

  // Table storage.
  fla_pkg::fla_wr_t wr;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   rd_a, rd_s;

  function automatic logic [31:0] cfg_round_sel(input logic [31:0] s);
    cfg_round_sel = round_r ? ((s + fla_pkg::PageMaskLow) & fla_pkg::PageMaskHigh) : s;
  endfunction

  logic [31:0] in_size_rnd;
  assign in_size_rnd = cfg_round_sel(in_tdata[64:33]);

  assign in_tready  = (state_r == S_IDLE) && !ovalid_r;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {lostb_r, lostc_r, 7'(peak_r), 7'(used_r), sum_r, ostat_r, ostart_r};

  // Shared compare unit for the scan.
  logic        fits;
  logic [31:0] rem;
  logic        take;
  assign fits = rd_s >= size_r;
  assign rem  = rd_s - size_r;
  always_comb begin
    if (!fit_r) take = fits && (!found_r || rd_s >= best_r);
    else        take = fits && (!found_r || rem < best_r);
  end

  logic [31:0] lost_sum;
  logic [32:0] lost_add;
  assign lost_add = {1'b0, lostb_r} + {1'b0, size_r};
  assign lost_sum = lost_add[32] ? 32'hffff_ffff : lost_add[31:0];

  logic [CW-1:0] kp1, km1;
  assign kp1 = k_r + CW'(1);
  assign km1 = k_r - CW'(1);

  // RAM port control: reads follow the index, shifts write in S_SHW.
  always_comb begin
    wr.wen       = 1'b0;
    wr.waddr_val = '0;
    wr.wsize_val = '0;
    waddr        = '0;
    raddr        = k_r[AW-1:0];
    if (state_r == S_SHW) begin
      wr.wen = 1'b1;
      wr.waddr_val = rd_a;
      wr.wsize_val = rd_s;
      waddr = (op_r == OP_DEL) ? km1[AW-1:0] : kp1[AW-1:0];
    end
  end

  // Sequencer registers: the decisions live here since they depend on state.
  logic [2:0] phase_r;   // step within the finish sequence
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_WRITE = 3'd1;
  localparam logic [2:0] PH_SHIFT = 3'd2;
  localparam logic [2:0] PH_TAIL  = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;

  logic [31:0] new_a, new_s;
  logic [AW-1:0] tail_at;
  logic          tail_wen;

  // Final-entry write, issued while shifts are idle.
  fla_pkg::fla_wr_t twr;
  always_comb begin
    twr.wen = tail_wen;
    twr.waddr_val = new_a;
    twr.wsize_val = new_s;
  end

  logic [AW-1:0] w_sel;
  fla_pkg::fla_wr_t w_mux;
  always_comb begin
    w_mux = wr;
    w_sel = waddr;
    if (twr.wen) begin
      w_mux = twr;
      w_sel = tail_at;
    end
  end

  // The RAM takes the muxed write.
  logic          ram_wen;
  assign ram_wen = w_mux.wen;

  fla_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_addr (
    .clk(clk), .wen(ram_wen), .waddr(w_sel), .wdata(w_mux.waddr_val),
    .raddr(raddr), .rdata(rd_a));
  fla_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_size (
    .clk(clk), .wen(ram_wen), .waddr(w_sel), .wdata(w_mux.wsize_val),
    .raddr(raddr), .rdata(rd_s));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fit_r    <= 1'b0;
      round_r  <= 1'b0;
      used_r   <= '0;
      peak_r   <= '0;
      lostc_r  <= '0;
      lostb_r  <= '0;
      sum_r    <= '0;
      ovalid_r <= 1'b0;
      rvalid_r <= 1'b0;
      phase_r  <= PH_START;
      tail_wen <= 1'b0;
    end else begin
      tail_wen <= (state_r == S_FIN) && (phase_r == PH_WRITE);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == fla_pkg::CfgFitPolicy) fit_r <= cfg_data;
        else                                    round_r <= cfg_data;
      end
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          type_r   <= in_tdata[0];
          addr_r   <= in_tdata[32:1];
          size_r   <= in_size_rnd;
          k_r      <= '0;
          rvalid_r <= 1'b0;
          found_r  <= 1'b0;
          best_r   <= '0;
          pos_r    <= used_r;
          ostart_r <= '0;
          ostat_r  <= fla_pkg::StOk;
          phase_r  <= PH_START;
          state_r  <= S_SCAN;
        end
        S_SCAN: begin
          // Issue a read per cycle; judge the entry read in the previous cycle.
          rvalid_r <= (k_r < used_r);
          rk_r     <= k_r;
          if (k_r < used_r) k_r <= kp1;
          if (rvalid_r) begin
            if (type_r == fla_pkg::ReqAlloc) begin
              if (take) begin
                found_r <= 1'b1;
                pick_r  <= rk_r[AW-1:0];
                best_r  <= fit_r ? rem : rd_s;
                pa_r    <= rd_a;
                ps_r    <= rd_s;
              end
            end else if (!found_r) begin
              if (rd_a > addr_r) begin
                found_r <= 1'b1;
                pos_r   <= rk_r;
                na_r    <= rd_a;
                ns_r    <= rd_s;
              end else begin
                pa_r <= rd_a;
                ps_r <= rd_s;
              end
            end
          end
          if (k_r >= used_r && !rvalid_r) state_r <= S_DEC;
        end
        S_DEC: begin
          state_r <= S_FIN;
          if (type_r == fla_pkg::ReqAlloc) begin
            if (size_r == '0 || !found_r) begin
              ostat_r <= fla_pkg::StNoFit;
              phase_r <= PH_DONE;
            end else begin
              ostart_r <= pa_r;
              sum_r    <= sum_r - size_r;
              if (ps_r == size_r) begin
                op_r    <= OP_DEL;
                used_r  <= used_r - CW'(1);
                k_r     <= CW'(pick_r) + CW'(1);
                phase_r <= PH_SHIFT;
              end else begin
                new_a   <= pa_r + size_r;
                new_s   <= ps_r - size_r;
                tail_at <= pick_r;
                phase_r <= PH_WRITE;
              end
            end
          end else if (size_r == '0) begin
            phase_r <= PH_DONE;
          end else if (pos_r != '0 && pa_r + ps_r == addr_r) begin
            sum_r   <= sum_r + size_r;
            tail_at <= AW'(pos_r - CW'(1));
            new_a   <= pa_r;
            if (pos_r < used_r && addr_r + size_r == na_r) begin
              new_s   <= ps_r + size_r + ns_r;
              op_r    <= OP_DEL;
              used_r  <= used_r - CW'(1);
              k_r     <= pos_r + CW'(1);
              phase_r <= PH_SHIFT;
            end else begin
              new_s   <= ps_r + size_r;
              phase_r <= PH_WRITE;
            end
          end else if (pos_r < used_r && addr_r + size_r == na_r) begin
            sum_r   <= sum_r + size_r;
            new_a   <= addr_r;
            new_s   <= ns_r + size_r;
            tail_at <= pos_r[AW-1:0];
            phase_r <= PH_WRITE;
          end else if (used_r < DepthC) begin
            sum_r   <= sum_r + size_r;
            new_a   <= addr_r;
            new_s   <= size_r;
            tail_at <= pos_r[AW-1:0];
            op_r    <= OP_INS;
            k_r     <= used_r;
            used_r  <= used_r + CW'(1);
            if (peak_r < used_r + CW'(1)) peak_r <= used_r + CW'(1);
            phase_r <= PH_SHIFT;
          end else begin
            ostat_r <= fla_pkg::StLost;
            lostc_r <= lostc_r + 32'd1;
            lostb_r <= lost_sum;
            phase_r <= PH_DONE;
          end
        end
        S_FIN: begin
          case (phase_r)
            PH_WRITE: begin
              phase_r  <= PH_TAIL;
            end
            PH_SHIFT: begin
              // Delete: move k to k-1 while k <= used. Insert: k-1 to k while k > pos.
              if (op_r == OP_DEL) begin
                if (k_r <= used_r) begin
                  state_r <= S_SHR;
                end else if (type_r == fla_pkg::ReqFree) begin
                  phase_r <= PH_WRITE;
                end else begin
                  phase_r <= PH_DONE;
                end
              end else begin
                if (k_r > pos_r) begin
                  k_r     <= km1;
                  state_r <= S_SHR;
                end else begin
                  phase_r <= PH_WRITE;
                end
              end
            end
            PH_TAIL: phase_r <= PH_DONE;
            PH_DONE: begin
              ovalid_r <= 1'b1;
              state_r  <= S_OUT;
            end
            default: phase_r <= PH_DONE;
          endcase
        end
        S_SHR: state_r <= S_SHW;
        S_SHW: begin
          if (op_r == OP_DEL) k_r <= kp1;
          state_r <= S_FIN;
        end
        S_OUT: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `FLA_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1, used_r <= DepthC)
  `FLA_ASSERT_IMP(a_peak_ge, clk, rst_n, 1'b1, peak_r >= used_r)
  `FLA_ASSERT_NXT(a_busy_block, clk, rst_n, (state_r != S_IDLE) && (state_r != S_OUT), !(in_tvalid && in_tready))
  `FLA_ASSERT_IMP(a_stat_code, clk, rst_n, ovalid_r, ostat_r <= fla_pkg::StLost)

endmodule

>>> tb/sv/free_list_allocator_test.sv
`timescale 1ns / 100ps

module free_list_allocator_test;

  // Result fields in the order they are packed on out_tdata.
  typedef struct packed {
    logic [31:0] lost_bytes;
    logic [31:0] lost_count;
    logic [6:0]  peak_entries;
    logic [6:0]  entry_count;
    logic [31:0] free_total;
    logic [1:0]  status;
    logic [31:0] alloc_start;
  } grant_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // [0] req_type, [32:1] range_start, [64:33] range_size, [71:65] zero
  logic [71:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // [31:0] alloc_start, [33:32] status, [65:34] free_total,
  // [72:66] entry_count, [79:73] peak_entries, [111:80] lost_count,
  // [143:112] lost_bytes
  logic [143:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic         cfg_index;
  logic         cfg_data;

  free_list_allocator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the free table and its counters.
  logic [31:0] shadow_addr [fla_pkg::TableDepth];
  logic [31:0] shadow_size [fla_pkg::TableDepth];
  int          shadow_used;
  int          shadow_peak;
  logic [31:0] shadow_lost_n;
  logic [31:0] shadow_lost_b;
  logic [31:0] shadow_sum;
  logic        shadow_best_fit;
  logic        shadow_page;

  grant_t grants_due [$];
  int     fail_count;
  int     rx_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("free_list_allocator verification failed");
    $finish;
  end

  function automatic void drop_entry(int pos);
    shadow_used--;
    for (int k = pos; k < shadow_used; k++) begin
      shadow_addr[k] = shadow_addr[k + 1];
      shadow_size[k] = shadow_size[k + 1];
    end
  endfunction

  // Applies one request to the shadow table and returns the expected result.
  function automatic grant_t apply_request(logic kind, logic [31:0] addr, logic [31:0] sz);
    grant_t      g;
    int          pick;
    int          i;
    logic [31:0] best;
    logic [31:0] rem;
    bit          found;
    bit          merged;
    g = '0;
    found = 0;
    merged = 0;
    pick = 0;
    best = 0;
    if (shadow_page) sz = (sz + fla_pkg::PageMaskLow) & fla_pkg::PageMaskHigh;
    if (kind == fla_pkg::ReqAlloc) begin
      g.status = fla_pkg::StNoFit;
      if (sz != 0) begin
        for (int k = 0; k < shadow_used; k++) begin
          if (shadow_size[k] < sz) continue;
          if (!shadow_best_fit) begin
            if (!found || shadow_size[k] >= best) begin
              found = 1; pick = k; best = shadow_size[k];
            end
          end else begin
            rem = shadow_size[k] - sz;
            if (!found || rem < best) begin
              found = 1; pick = k; best = rem;
            end
          end
        end
      end
      if (found) begin
        g.status = fla_pkg::StOk;
        g.alloc_start = shadow_addr[pick];
        shadow_addr[pick] += sz;
        shadow_size[pick] -= sz;
        shadow_sum -= sz;
        if (shadow_size[pick] == 0) drop_entry(pick);
      end
    end else begin
      g.status = fla_pkg::StOk;
      if (sz != 0) begin
        for (i = 0; i < shadow_used; i++) begin
          if (shadow_addr[i] > addr) break;
        end
        if (i > 0 && shadow_addr[i - 1] + shadow_size[i - 1] == addr) begin
          shadow_size[i - 1] += sz;
          shadow_sum += sz;
          if (i < shadow_used && addr + sz == shadow_addr[i]) begin
            shadow_size[i - 1] += shadow_size[i];
            drop_entry(i);
          end
          merged = 1;
        end else if (i < shadow_used && addr + sz == shadow_addr[i]) begin
          shadow_addr[i] = addr;
          shadow_size[i] += sz;
          shadow_sum += sz;
          merged = 1;
        end
        if (!merged) begin
          if (shadow_used < fla_pkg::TableDepth) begin
            for (int j = shadow_used; j > i; j--) begin
              shadow_addr[j] = shadow_addr[j - 1];
              shadow_size[j] = shadow_size[j - 1];
            end
            shadow_addr[i] = addr;
            shadow_size[i] = sz;
            shadow_used++;
            if (shadow_peak < shadow_used) shadow_peak = shadow_used;
            shadow_sum += sz;
          end else begin
            g.status = fla_pkg::StLost;
            shadow_lost_n++;
            shadow_lost_b = (shadow_lost_b > 32'hffff_ffff - sz) ? 32'hffff_ffff
                                                                 : shadow_lost_b + sz;
          end
        end
      end
    end
    g.free_total   = shadow_sum;
    g.entry_count  = 7'(shadow_used);
    g.peak_entries = 7'(shadow_peak);
    g.lost_count   = shadow_lost_n;
    g.lost_bytes   = shadow_lost_b;
    return g;
  endfunction

  // Sends one request after a random gap and queues its expected result.
  // The valid stays up after an accept until the next gap or drain drops it.
  task automatic send_request(logic kind, logic [31:0] addr, logic [31:0] sz);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, sz, addr, kind};
    do @(posedge clk); while (!in_tready);
    grants_due.push_back(apply_request(kind, addr, sz));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == fla_pkg::CfgFitPolicy) shadow_best_fit = val;
    else shadow_page = val;
    @(posedge clk);
  endtask

  // Result checker with a random ready pattern and an optional long hold.
  initial begin
    grant_t got;
    grant_t want;
    int     stall;
    out_tready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = grant_t'(out_tdata);
        if (grants_due.size() == 0) begin
          $display("%0t unexpected result %h", $time, got);
          fail_count++;
        end else begin
          want = grants_due.pop_front();
          if (got.alloc_start !== want.alloc_start)
            $display("%0t alloc_start exp %h got %h", $time, want.alloc_start, got.alloc_start);
          if (got.status !== want.status)
            $display("%0t status exp %0d got %0d", $time, want.status, got.status);
          if (got.free_total !== want.free_total)
            $display("%0t free_total exp %h got %h", $time, want.free_total, got.free_total);
          if (got.entry_count !== want.entry_count)
            $display("%0t entry_count exp %0d got %0d", $time, want.entry_count,
                     got.entry_count);
          if (got.peak_entries !== want.peak_entries)
            $display("%0t peak_entries exp %0d got %0d", $time, want.peak_entries,
                     got.peak_entries);
          if (got.lost_count !== want.lost_count)
            $display("%0t lost_count exp %h got %h", $time, want.lost_count, got.lost_count);
          if (got.lost_bytes !== want.lost_bytes)
            $display("%0t lost_bytes exp %h got %h", $time, want.lost_bytes, got.lost_bytes);
          if (got !== want) fail_count++;
        end
        stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 10);
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Corners: empty table, zero sizes, wrap, merges, both policies.
  task automatic test_directed();
    send_request(fla_pkg::ReqAlloc, 32'd0, 32'd16);
    send_request(fla_pkg::ReqAlloc, 32'hffff_ffff, 32'd0);
    send_request(fla_pkg::ReqFree, 32'd5, 32'd0);
    send_request(fla_pkg::ReqFree, 32'h0000_1000, 32'h100);
    send_request(fla_pkg::ReqFree, 32'h0000_1200, 32'h100);
    send_request(fla_pkg::ReqFree, 32'h0000_1100, 32'h100);
    send_request(fla_pkg::ReqFree, 32'h0000_0f00, 32'h100);
    send_request(fla_pkg::ReqFree, 32'h0000_1300, 32'h80);
    send_request(fla_pkg::ReqFree, 32'hffff_ff00, 32'h100);
    send_request(fla_pkg::ReqFree, 32'h8000_0000, 32'hffff_ffff);
    send_request(fla_pkg::ReqFree, 32'h0000_1000, 32'h10);
    send_request(fla_pkg::ReqAlloc, 32'd0, 32'hffff_ffff);
    send_request(fla_pkg::ReqAlloc, 32'd0, 32'h80);
    send_request(fla_pkg::ReqAlloc, 32'd0, 32'h480);
    drain();
    write_reg(fla_pkg::CfgFitPolicy, 1'b1);
    send_request(fla_pkg::ReqAlloc, 32'd0, 32'h10);
    send_request(fla_pkg::ReqAlloc, 32'd0, 32'h100);
    send_request(fla_pkg::ReqAlloc, 32'd0, 32'hffff_fff0);
    drain();
    write_reg(fla_pkg::CfgPageRound, 1'b1);
    send_request(fla_pkg::ReqAlloc, 32'd0, 32'hffff_f001);
    send_request(fla_pkg::ReqFree, 32'h4000_0000, 32'd1);
    send_request(fla_pkg::ReqAlloc, 32'd0, 32'd1);
    send_request(fla_pkg::ReqFree, 32'h5000_0000, 32'hffff_f000);
    drain();
  endtask

  // Random traffic mostly within a small window so merges and fits happen often.
  task automatic test_random(int count, logic best, logic page);
    logic [31:0] a;
    logic [31:0] s;
    drain();
    write_reg(fla_pkg::CfgFitPolicy, best);
    write_reg(fla_pkg::CfgPageRound, page);
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0: begin a = $urandom(); s = $urandom(); end
        1, 2, 3: begin a = $urandom_range(0, 255) << 12; s = $urandom_range(1, 8) << 12; end
        default: begin a = $urandom_range(0, 4095) << 4; s = $urandom_range(1, 64) << 4; end
      endcase
      send_request(($urandom_range(0, 2) == 0) ? fla_pkg::ReqAlloc : fla_pkg::ReqFree, a, s);
    end
    drain();
  endtask

  // Fill the table past its depth while the result side holds off.
  task automatic test_fill_and_hold();
    rx_hold_cycles = 3000;
    for (int n = 0; n < fla_pkg::TableDepth + 8; n++)
      send_request(fla_pkg::ReqFree, 32'h1000_0000 + (n << 8), 32'h80);
    send_request(fla_pkg::ReqFree, 32'h2000_0000, 32'hffff_ffff);
    send_request(fla_pkg::ReqFree, 32'h2100_0000, 32'hffff_ffff);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = fla_pkg::CfgFitPolicy;
    cfg_data = 1'b0;
    fail_count = 0;
    rx_hold_cycles = 0;
    shadow_used = 0;
    shadow_peak = 0;
    shadow_lost_n = 0;
    shadow_lost_b = 0;
    shadow_sum = 0;
    shadow_best_fit = 1'b0;
    shadow_page = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300, 1'b0, 1'b0);
    test_random(300, 1'b1, 1'b0);
    test_fill_and_hold();
    test_random(200, 1'b1, 1'b1);
    test_random(200, 1'b0, 1'b1);
    if (fail_count == 0) begin
      $display("free_list_allocator verification clean");
    end else begin
      $display("free_list_allocator verification failed");
    end
    $finish;
  end

endmodule
